// ----- hw/rtl/csvx_pkg.sv -----
`default_nettype none
package csvx_pkg;

   // default sizes of the key store and of the hash
   localparam int MAX_KEY_BYTES_DEF = 511;
   localparam int HASH_BITS_DEF     = 13;

   localparam int BYTE_W     = 8;
   localparam int BUCKET_W   = 13;
   localparam int FIELD_W    = 11;
   localparam int COLUMN_W   = 10;
   localparam int HASH_SEED  = 5381;

   localparam logic [FIELD_W-1:0] FIELD_MAX = 11'd2047;

   localparam logic [BYTE_W-1:0] CH_QUOTE = 8'h22;
   localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
   localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;

   // register indexes on the configuration port
   localparam logic REG_TARGET_COLUMN = 1'b0;
   localparam logic REG_DROP_MODE     = 1'b1;

   // queue between the front and the back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   typedef enum logic [1:0] {
      CLS_OTHER,
      CLS_QUOTE,
      CLS_COMMA,
      CLS_CR
   } byte_class_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              end_of_line;
      byte_class_type    byte_class;
   } item_type;

   typedef struct packed {
      logic [COLUMN_W-1:0] target_column;
      logic                drop_mode;
   } cfg_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage
`default_nettype wire

// ----- hw/rtl/csvx_req_if.sv -----
`default_nettype none
interface csvx_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_line;

   modport source (output valid, output data_byte, output end_of_line, input ready);
   modport sink (input valid, input data_byte, input end_of_line, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/csvx_rsp_if.sv -----
`default_nettype none
interface csvx_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_byte;
   logic        byte_valid;
   logic        last_of_line;
   logic [12:0] bucket_index;

   modport source (output valid, output out_byte, output byte_valid, output last_of_line,
                   output bucket_index, input ready);
   modport sink (input valid, input out_byte, input byte_valid, input last_of_line,
                 input bucket_index, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/csv_column_extract_or_drop_core.sv -----
`default_nettype none
// csv column extractor / dropper
//
// req_chan carries one line byte per transfer, or an end-of-line marker that
// carries no byte. rsp_chan carries at most one result per request: a value
// byte or inserted comma (byte_valid high), or the closing result of the line
// (last_of_line high, bucket_index holding the hash bucket in extract mode).
// target_column and drop_mode sit on the apb port at byte addresses 0 and 4;
// write them only while no line is in flight.
//
// throughput is one request per cycle, sustained while rsp_chan is ready. a
// request taken from req_chan is written into a four-entry queue; the parser
// pops it and loads its result into the output register, so a result passes
// the queue and then the output register. the parser state update and the
// shift-add hash settle in the cycle of the pop.
// a stalled rsp_chan holds the output register and the parser; requests keep
// being taken until the queue fills, then req_chan.ready drops.
// reset (synchronous) empties the queue and output register, clears both
// registers and returns the parser to the start of a line.
module csv_column_extract_or_drop_core
   import csvx_pkg::*;
#(
   parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_DEF,
   parameter int HASH_BITS     = HASH_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   csvx_req_if.sink         req_chan,
   csvx_rsp_if.source       rsp_chan,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   cfg_type          cfg_ff, cfg_in;
   logic             reg_sel;
   logic             csr_write;
   logic             push;
   logic             pop;
   item_type         push_item;
   item_type         head_item;
   queue_status_type status;

   assign reg_sel   = paddr[2];
   assign csr_write = psel && penable && pwrite;
   assign pready    = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (reg_sel)
            REG_TARGET_COLUMN: cfg_in.target_column = pwdata[COLUMN_W-1:0];
            REG_DROP_MODE:     cfg_in.drop_mode     = pwdata[0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_TARGET_COLUMN: prdata = 32'(cfg_ff.target_column);
         REG_DROP_MODE:     prdata = 32'(cfg_ff.drop_mode);
         default:           prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   csvx_front u_front (
      .queue_full (status.full),
      .in_valid   (req_chan.valid),
      .in_byte    (req_chan.data_byte),
      .in_eol     (req_chan.end_of_line),
      .in_ready   (req_chan.ready),
      .push       (push),
      .push_item  (push_item)
   );

   csvx_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .status    (status)
   );

   csvx_back #(
      .MAX_KEY_BYTES (MAX_KEY_BYTES),
      .HASH_BITS     (HASH_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .head_item      (head_item),
      .status         (status),
      .pop            (pop),
      .out_valid      (rsp_chan.valid),
      .out_ready      (rsp_chan.ready),
      .out_byte       (rsp_chan.out_byte),
      .out_byte_valid (rsp_chan.byte_valid),
      .out_last       (rsp_chan.last_of_line),
      .out_bucket     (rsp_chan.bucket_index)
   );

endmodule
`default_nettype wire

// ----- hw/rtl/csvx_front.sv -----
`default_nettype none
module csvx_front
   import csvx_pkg::*;
(
   input  wire logic              queue_full,
   input  wire logic              in_valid,
   input  wire logic [BYTE_W-1:0] in_byte,
   input  wire logic              in_eol,
   output logic                   in_ready,
   output logic                   push,
   output item_type               push_item
);

   byte_class_type cls;

   always_comb begin
      if (in_byte == CH_QUOTE) begin
         cls = CLS_QUOTE;
      end else if (in_byte == CH_COMMA) begin
         cls = CLS_COMMA;
      end else if (in_byte == CH_CR) begin
         cls = CLS_CR;
      end else begin
         cls = CLS_OTHER;
      end
   end

   assign in_ready              = !queue_full;
   assign push                  = in_valid && !queue_full;
   assign push_item.data_byte   = in_byte;
   assign push_item.end_of_line = in_eol;
   assign push_item.byte_class  = cls;

endmodule
`default_nettype wire

// ----- hw/rtl/csvx_queue.sv -----
`default_nettype none
module csvx_queue
   import csvx_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire item_type   push_item,
   input  wire logic       pop,
   output item_type        head_item,
   output queue_status_type status
);

   item_type           entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_item    = entries_ff[rd_ptr_ff];
   assign status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);

endmodule
`default_nettype wire

// ----- hw/rtl/csvx_back.sv -----
`default_nettype none
module csvx_back
   import csvx_pkg::*;
#(
   parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_DEF,
   parameter int HASH_BITS     = HASH_BITS_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire cfg_type          cfg,
   input  wire item_type         head_item,
   input  wire queue_status_type status,
   output logic                  pop,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output logic [BYTE_W-1:0]     out_byte,
   output logic                  out_byte_valid,
   output logic                  out_last,
   output logic [BUCKET_W-1:0]   out_bucket
);

   localparam int KL_W = $clog2(MAX_KEY_BYTES + 1);
   localparam int SUM_W = HASH_BITS + 9;

   localparam logic [2:0] PH_START  = 3'd0;
   localparam logic [2:0] PH_PLAIN  = 3'd1;
   localparam logic [2:0] PH_QUOTED = 3'd2;
   localparam logic [2:0] PH_QSEEN  = 3'd3;
   localparam logic [2:0] PH_DONE   = 3'd4;

   localparam logic [HASH_BITS-1:0] HASH_INIT = HASH_BITS'(HASH_SEED);

   logic [2:0]           phase_ff, phase_in;
   logic [FIELD_W-1:0]   field_ff, field_in;
   logic [KL_W-1:0]      klen_ff, klen_in;
   logic [HASH_BITS-1:0] hash_ff, hash_in;

   logic                 res_valid_ff, res_valid_in;
   logic [BYTE_W-1:0]    res_byte_ff, res_byte_in;
   logic                 res_bv_ff, res_bv_in;
   logic                 res_last_ff, res_last_in;
   logic [BUCKET_W-1:0]  res_bucket_ff, res_bucket_in;

   logic                 tgt;
   logic [FIELD_W-1:0]   field_inc;
   logic                 comma_sep;
   logic                 key_take;
   logic                 copy;
   logic                 boundary;
   logic                 emit;
   logic [BYTE_W-1:0]    emit_byte;
   logic [KL_W-1:0]      klen_inc;
   logic [SUM_W-1:0]     hash_sum;
   logic [31:0]          hash_wide;
   logic [BYTE_W-1:0]    ch;
   byte_class_type       cls;

   assign ch  = head_item.data_byte;
   assign cls = head_item.byte_class;
   assign pop = !status.empty && (!res_valid_ff || out_ready);

   assign tgt       = (field_ff == {1'b0, cfg.target_column});
   assign field_inc = (field_ff < FIELD_MAX) ? field_ff + 1'b1 : field_ff;
   assign comma_sep = (field_inc != {1'b0, cfg.target_column})
                    && ((field_inc >= FIELD_W'(2)) || (cfg.target_column != '0));
   assign klen_inc  = klen_ff + 1'b1;
   // times 33 as shift plus add
   assign hash_sum  = {4'b0, hash_ff, 5'b0} + SUM_W'(hash_ff) + SUM_W'(ch);
   assign hash_wide = 32'(hash_ff);

   always_comb begin
      phase_in  = phase_ff;
      field_in  = field_ff;
      klen_in   = klen_ff;
      hash_in   = hash_ff;
      key_take  = 1'b0;
      copy      = 1'b0;
      boundary  = 1'b0;
      emit      = 1'b0;
      emit_byte = ch;

      res_valid_in  = res_valid_ff && !out_ready;
      res_byte_in   = res_byte_ff;
      res_bv_in     = res_bv_ff;
      res_last_in   = res_last_ff;
      res_bucket_in = res_bucket_ff;

      if (pop) begin
         if (head_item.end_of_line) begin
            phase_in      = PH_START;
            field_in      = '0;
            klen_in       = '0;
            hash_in       = HASH_INIT;
            res_valid_in  = 1'b1;
            res_byte_in   = '0;
            res_bv_in     = 1'b0;
            res_last_in   = 1'b1;
            res_bucket_in = cfg.drop_mode ? '0 : hash_wide[BUCKET_W-1:0];
         end else begin
            if (!cfg.drop_mode) begin
               case (phase_ff)
                  PH_START: begin
                     if (cls == CLS_QUOTE) begin
                        phase_in = PH_QUOTED;
                     end else if (tgt) begin
                        if (cls == CLS_COMMA || cls == CLS_CR) begin
                           phase_in = PH_DONE;
                        end else begin
                           phase_in = PH_PLAIN;
                           key_take = 1'b1;
                        end
                     end else if (cls == CLS_COMMA) begin
                        field_in = field_inc;
                     end else begin
                        phase_in = PH_PLAIN;
                     end
                  end
                  PH_PLAIN: begin
                     if (tgt) begin
                        if (cls == CLS_COMMA || cls == CLS_CR) begin
                           phase_in = PH_DONE;
                        end else begin
                           key_take = 1'b1;
                        end
                     end else if (cls == CLS_COMMA) begin
                        field_in = field_inc;
                        phase_in = PH_START;
                     end
                  end
                  PH_QUOTED: begin
                     if (cls == CLS_QUOTE) begin
                        phase_in = PH_QSEEN;
                     end else begin
                        key_take = tgt;
                     end
                  end
                  PH_QSEEN: begin
                     if (cls == CLS_QUOTE) begin
                        // doubled quote gives one quote
                        phase_in = PH_QUOTED;
                        key_take = tgt;
                     end else if (tgt) begin
                        phase_in = PH_DONE;
                     end else if (cls == CLS_COMMA) begin
                        field_in = field_inc;
                        phase_in = PH_START;
                     end else begin
                        phase_in = PH_PLAIN;
                     end
                  end
                  default: begin
                  end
               endcase
            end else begin
               case (phase_ff)
                  PH_START: begin
                     if (cls == CLS_CR) begin
                        phase_in = PH_DONE;
                     end else if (cls == CLS_COMMA) begin
                        boundary = 1'b1;
                     end else begin
                        phase_in = (cls == CLS_QUOTE) ? PH_QUOTED : PH_PLAIN;
                        copy     = 1'b1;
                     end
                  end
                  PH_PLAIN: begin
                     if (cls == CLS_COMMA) begin
                        boundary = 1'b1;
                     end else begin
                        copy = 1'b1;
                     end
                  end
                  PH_QUOTED: begin
                     if (cls == CLS_QUOTE) begin
                        phase_in = PH_QSEEN;
                     end
                     copy = 1'b1;
                  end
                  PH_QSEEN: begin
                     if (cls == CLS_QUOTE) begin
                        phase_in = PH_QUOTED;
                        copy     = 1'b1;
                     end else if (cls == CLS_COMMA) begin
                        boundary = 1'b1;
                     end else begin
                        phase_in = PH_PLAIN;
                        copy     = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end

            if (key_take) begin
               emit    = 1'b1;
               hash_in = hash_sum[HASH_BITS-1:0];
               klen_in = klen_inc;
               if (klen_inc >= KL_W'(MAX_KEY_BYTES)) begin
                  phase_in = PH_DONE;
               end
            end
            if (copy && !tgt) begin
               emit = 1'b1;
            end
            if (boundary) begin
               field_in = field_inc;
               phase_in = PH_START;
               if (comma_sep) begin
                  emit      = 1'b1;
                  emit_byte = CH_COMMA;
               end
            end

            if (emit) begin
               res_valid_in  = 1'b1;
               res_byte_in   = emit_byte;
               res_bv_in     = 1'b1;
               res_last_in   = 1'b0;
               res_bucket_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_START;
         field_ff     <= '0;
         klen_ff      <= '0;
         hash_ff      <= HASH_INIT;
         res_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         field_ff     <= field_in;
         klen_ff      <= klen_in;
         hash_ff      <= hash_in;
         res_valid_ff <= res_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_byte_ff   <= res_byte_in;
      res_bv_ff     <= res_bv_in;
      res_last_ff   <= res_last_in;
      res_bucket_ff <= res_bucket_in;
   end

   assign out_valid      = res_valid_ff;
   assign out_byte       = res_byte_ff;
   assign out_byte_valid = res_bv_ff;
   assign out_last       = res_last_ff;
   assign out_bucket     = res_bucket_ff;

endmodule
`default_nettype wire
